// ===== rtl/adam_pkg.sv =====
// Shared types and constants of the fixed-point Adam update block.
// No dependencies; adam_moment, the top level and the testbench refer to it by scoped names.
package adam_pkg;

    localparam int FRAC     = 24;     // fraction bits of values and rates
    localparam int ELEMENTS = 4096;   // entries of each moment store
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 32;
    localparam int RATE_W   = 25;

    localparam logic [RATE_W-1:0] ONE_Q      = 25'd16777216;
    localparam logic [RATE_W-1:0] LR_RESET   = 25'd16777;
    localparam logic [RATE_W-1:0] B1_RESET   = 25'd15099494;
    localparam logic [RATE_W-1:0] B2_RESET   = 25'd16760439;
    localparam logic [RATE_W-1:0] EPS_RESET  = 25'd1;

    typedef enum logic [1:0] {
        CFG_LEARNING_RATE = 2'd0,
        CFG_BETA_FIRST    = 2'd1,
        CFG_BETA_SECOND   = 2'd2,
        CFG_EPSILON       = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        ACT_UPDATE  = 1'b0,
        ACT_ADVANCE = 1'b1
    } t_action;

    typedef struct packed {
        logic                    action;
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] gradient;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        result_index;
        logic signed [VAL_W-1:0] update_step;
        logic                    saturated;
    } t_out_item;

    // Result of the moment stages, handed to the bias-correction datapath.
    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  idx;
        logic              mneg;
        logic [VAL_W-1:0]  am;
        logic [VAL_W-1:0]  v;
        logic [RATE_W-1:0] c1;
        logic [RATE_W-1:0] c2;
        logic              sat;
    } t_moment;

    function automatic logic [RATE_W-1:0] clamp_one(input logic [RATE_W-1:0] x);
        return (x > ONE_Q) ? ONE_Q : x;
    endfunction

endpackage

// ===== rtl/adam_optimizer_update.sv =====
// Top level of the fixed-point Adam update block: configuration registers,
// bias correction, root and step datapath, output register with skid stage.
// Uses adam_pkg, adam_moment, adam_div and adam_sqrt.
//
// Usage. Input items arrive on i_valid / i_item and are taken at a rising edge
// where i_valid is high and o_stall is low. An update item refreshes the two
// moments of one element and returns its step; an advance item multiplies the
// running beta powers by the betas and returns an all-zero result. Every item
// yields exactly one result on o_valid / o_result, taken when i_stall is low.
// The user must write configuration through i_cfg_valid / i_cfg_index / i_cfg_data
// only while the block is idle; the block does not enforce this, as o_cfg_ready
// is always high. One item can enter every cycle while o_stall is low; the four
// long units (three dividers, one square root) produce one bit per stage, which
// sets the depth. An update to an element still in the first four moment stages
// holds o_stall until the earlier write has landed. After reset the moment
// stores are swept to zero, one entry per cycle, with o_stall held high. When the
// receiver stalls a result, the pipeline keeps moving until the next result has
// entered the skid stage, then freezes in place.
module adam_optimizer_update (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  adam_pkg::t_in_item           i_item,
    output logic                         o_valid,
    input  logic                         i_stall,
    output adam_pkg::t_out_item          o_result,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [adam_pkg::RATE_W-1:0]  i_cfg_data
);

    localparam int VW = adam_pkg::VAL_W;
    localparam int IW = adam_pkg::IDX_W;
    localparam int RW = adam_pkg::RATE_W;
    localparam int FR = adam_pkg::FRAC;
    localparam int NW = VW + FR;        // dividend width of every division
    localparam int SW = NW / 2;         // root width
    localparam int DW = SW + 1;         // root plus epsilon

    localparam logic [VW-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [VW-1:0] NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic          action;
        logic [IW-1:0] idx;
        logic          mneg;
        logic          sat;
        logic          m_spec;
        logic          am_zero;
    } t_tag_div;

    typedef struct packed {
        logic          action;
        logic [IW-1:0] idx;
        logic          mneg;
        logic          sat;
        logic [VW-1:0] mhat;
    } t_tag_root;

    typedef struct packed {
        logic          action;
        logic [IW-1:0] idx;
        logic          mneg;
        logic          sat;
        logic          ovf;
    } t_tag_step;

    // Configuration registers.
    logic [RW-1:0] r_lr, r_b1, r_b2, r_eps;
    logic [RW-1:0] lr_c, b1_c, b2_c, eps_c, eps_eff;

    logic adv, accept;

    // Moment stages.
    logic              mo_vld;
    adam_pkg::t_moment mo_res;

    // Bias-correction setup stage.
    logic          rp_vld, rp_vspec;
    t_tag_div      rp_tag, n_rp_tag;
    logic [NW-1:0] rp_num_m, rp_num_v;
    logic [RW-1:0] rp_den_m, rp_den_v;
    logic          n_m_ovf, n_v_ovf, n_vspec;

    // Divider outputs.
    logic          dm_vld, dv_vld, dv_tag;
    logic [VW-1:0] dm_quo, dv_quo;
    t_tag_div      dm_tag;

    // Corrected moments.
    logic          rq_vld;
    t_tag_root     rq_tag, n_rq_tag;
    logic [VW-1:0] rq_vhat, q_lim;

    // Root output and step setup.
    logic          sq_vld;
    logic [SW-1:0] sq_root;
    t_tag_root     sq_tag;
    logic          rr_vld;
    t_tag_step     rr_tag;
    logic [NW-1:0] rr_prod;
    logic [DW-1:0] rr_den;
    logic [VW+RW-1:0] n_prod;

    logic          rs_vld;
    t_tag_step     rs_tag;
    logic [NW-1:0] rs_prod;
    logic [DW-1:0] rs_den;

    logic          ds_vld;
    logic [VW-1:0] ds_quo;
    t_tag_step     ds_tag;

    // Final result and output registers.
    adam_pkg::t_out_item f_item, r_out, r_skid;
    logic [VW-1:0]       f_mag, f_lim;
    logic                f_sat;
    logic                r_out_vld, r_skid_vld;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr  <= adam_pkg::LR_RESET;
            r_b1  <= adam_pkg::B1_RESET;
            r_b2  <= adam_pkg::B2_RESET;
            r_eps <= adam_pkg::EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                adam_pkg::CFG_LEARNING_RATE: r_lr  <= i_cfg_data;
                adam_pkg::CFG_BETA_FIRST:    r_b1  <= i_cfg_data;
                adam_pkg::CFG_BETA_SECOND:   r_b2  <= i_cfg_data;
                adam_pkg::CFG_EPSILON:       r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Registers above 1.0 act as 1.0; a zero epsilon acts as the smallest step.
    assign lr_c    = adam_pkg::clamp_one(r_lr);
    assign b1_c    = adam_pkg::clamp_one(r_b1);
    assign b2_c    = adam_pkg::clamp_one(r_b2);
    assign eps_c   = adam_pkg::clamp_one(r_eps);
    assign eps_eff = (eps_c == '0) ? RW'(1) : eps_c;

    // The whole pipeline moves unless the skid stage is holding an item.
    assign adv    = !r_skid_vld;
    assign accept = i_valid && !o_stall;

    adam_moment u_moment (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (i_valid),
        .i_item        (i_item),
        .i_beta_first  (b1_c),
        .i_beta_second (b2_c),
        .o_stall       (o_stall),
        .o_vld         (mo_vld),
        .o_res         (mo_res)
    );

    // The quotient of a bias correction fits 32 bits exactly when the moment
    // is below the correction shifted up by 32 - FRAC bits; otherwise it clips.
    assign n_m_ovf = {1'b0, mo_res.am} >= {mo_res.c1, {(VW-FR){1'b0}}};
    assign n_v_ovf = {1'b0, mo_res.v}  >= {mo_res.c2, {(VW-FR){1'b0}}};
    assign n_vspec = n_v_ovf || (mo_res.c2 == '0);

    always_comb begin
        n_rp_tag.action  = mo_res.action;
        n_rp_tag.idx     = mo_res.idx;
        n_rp_tag.mneg    = mo_res.mneg;
        n_rp_tag.m_spec  = n_m_ovf || (mo_res.c1 == '0);
        n_rp_tag.am_zero = mo_res.am == '0;
        n_rp_tag.sat     = mo_res.sat || n_rp_tag.m_spec || n_vspec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rp_vld <= 1'b0;
            rq_vld <= 1'b0;
            rr_vld <= 1'b0;
            rs_vld <= 1'b0;
        end else if (adv) begin
            rp_vld <= mo_vld;
            rq_vld <= dm_vld;
            rr_vld <= sq_vld;
            rs_vld <= rr_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rp_tag   <= n_rp_tag;
            rp_vspec <= n_vspec;
            rp_num_m <= {mo_res.am, {FR{1'b0}}};
            rp_num_v <= {mo_res.v, {FR{1'b0}}};
            rp_den_m <= mo_res.c1;
            rp_den_v <= mo_res.c2;
        end
    end

    adam_div #(.NUM_W(NW), .DEN_W(RW), .QUO_W(VW), .TAG_W($bits(t_tag_div))) u_div_m (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (rp_vld),
        .i_num   (rp_num_m),
        .i_den   (rp_den_m),
        .i_tag   (rp_tag),
        .o_vld   (dm_vld),
        .o_quo   (dm_quo),
        .o_tag   (dm_tag)
    );

    adam_div #(.NUM_W(NW), .DEN_W(RW), .QUO_W(VW), .TAG_W(1)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (rp_vld),
        .i_num   (rp_num_v),
        .i_den   (rp_den_v),
        .i_tag   (rp_vspec),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_tag   (dv_tag)
    );

    // Corrected first moment: clipped to the range of its sign. A zero
    // correction gives the extreme value, or zero when the moment is zero.
    assign q_lim = dm_tag.mneg ? NEG_LIM : POS_LIM;

    always_comb begin
        n_rq_tag.action = dm_tag.action;
        n_rq_tag.idx    = dm_tag.idx;
        n_rq_tag.mneg   = dm_tag.mneg;
        n_rq_tag.sat    = dm_tag.sat;
        if (dm_tag.m_spec) begin
            n_rq_tag.mhat = dm_tag.am_zero ? '0 : q_lim;
        end else if (dm_quo > q_lim) begin
            n_rq_tag.mhat = q_lim;
            n_rq_tag.sat  = 1'b1;
        end else begin
            n_rq_tag.mhat = dm_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rq_tag  <= n_rq_tag;
            rq_vhat <= dv_tag ? '1 : dv_quo;
        end
    end

    adam_sqrt #(.IN_W(NW), .TAG_W($bits(t_tag_root))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (rq_vld),
        .i_x     ({rq_vhat, {FR{1'b0}}}),
        .i_tag   (rq_tag),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    assign n_prod = sq_tag.mhat * lr_c;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            rr_tag.action <= sq_tag.action;
            rr_tag.idx    <= sq_tag.idx;
            rr_tag.mneg   <= sq_tag.mneg;
            rr_tag.sat    <= sq_tag.sat;
            rr_tag.ovf    <= 1'b0;
            rr_prod       <= n_prod[NW-1:0];
            rr_den        <= DW'(sq_root) + DW'(eps_eff);

            // The step quotient needs more than 32 bits exactly when the
            // product reaches the denominator shifted up by 32 bits.
            rs_tag.action <= rr_tag.action;
            rs_tag.idx    <= rr_tag.idx;
            rs_tag.mneg   <= rr_tag.mneg;
            rs_tag.sat    <= rr_tag.sat;
            rs_tag.ovf    <= {{(VW+DW-NW){1'b0}}, rr_prod} >= {rr_den, {VW{1'b0}}};
            rs_prod       <= rr_prod;
            rs_den        <= rr_den;
        end
    end

    adam_div #(.NUM_W(NW), .DEN_W(DW), .QUO_W(VW), .TAG_W($bits(t_tag_step))) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (rs_vld),
        .i_num   (rs_prod),
        .i_den   (rs_den),
        .i_tag   (rs_tag),
        .o_vld   (ds_vld),
        .o_quo   (ds_quo),
        .o_tag   (ds_tag)
    );

    // Final clip to the signed range and sign restore; advance items give zero.
    assign f_lim = ds_tag.mneg ? NEG_LIM : POS_LIM;

    always_comb begin
        f_mag = ds_tag.ovf ? '1 : ds_quo;
        f_sat = ds_tag.sat;
        if (f_mag > f_lim) begin
            f_mag = f_lim;
            f_sat = 1'b1;
        end
        if (ds_tag.action == adam_pkg::ACT_ADVANCE) begin
            f_item.result_index = '0;
            f_item.update_step  = '0;
            f_item.saturated    = 1'b0;
        end else begin
            f_item.result_index = ds_tag.idx;
            f_item.update_step  = ds_tag.mneg ? VW'(-f_mag) : f_mag;
            f_item.saturated    = f_sat;
        end
    end

    // Output register plus one skid entry, so the pipeline sees a registered
    // hold signal rather than the receiver's stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_out_vld && i_stall) begin
            if (ds_vld && adv) begin
                r_skid_vld <= 1'b1;
            end
        end else if (r_skid_vld) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld <= ds_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_vld && i_stall) begin
            if (adv) begin
                r_skid <= f_item;
            end
        end else if (r_skid_vld) begin
            r_out <= r_skid;
        end else begin
            r_out <= f_item;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // The skid entry is only occupied behind a waiting result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry holds an item while the output register is empty");

    // The skid entry fills only when the receiver stalled a valid result.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && i_stall))
        else $error("skid entry filled without a stalled result");

    // The two correction dividers run in lockstep.
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dm_vld == dv_vld)
        else $error("moment dividers out of step");

    // No item enters while the pipeline is frozen.
    a_no_accept_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> adv)
        else $error("item accepted while the pipeline is frozen");

endmodule

// ===== rtl/adam_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// Depends on nothing; the caller guarantees the quotient fits in QUO_W bits.
module adam_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 25,
    parameter int QUO_W = 32,
    parameter int TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic             r_vld [QUO_W];
    logic [DEN_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_low [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [TAG_W-1:0] r_tag [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic             s_vld;
        logic [DEN_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [QUO_W-1:0] s_low;
        logic [QUO_W-1:0] s_quo;
        logic [TAG_W-1:0] s_tag;
        logic [DEN_W:0]   s_trial;
        logic             s_take;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_rem = DEN_W'(i_num[NUM_W-1:QUO_W]);
            assign s_den = i_den;
            assign s_low = i_num[QUO_W-1:0];
            assign s_quo = '0;
            assign s_tag = i_tag;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_low = r_low[k-1];
            assign s_quo = r_quo[k-1];
            assign s_tag = r_tag[k-1];
        end

        assign s_trial = {s_rem, s_low[QUO_W-1]};
        assign s_take  = s_trial >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= s_take ? DEN_W'(s_trial - {1'b0, s_den}) : DEN_W'(s_trial);
                r_den[k] <= s_den;
                r_low[k] <= {s_low[QUO_W-2:0], 1'b0};
                r_quo[k] <= {s_quo[QUO_W-2:0], s_take};
                r_tag[k] <= s_tag;
            end
        end
    end

    assign o_vld = r_vld[QUO_W-1];
    assign o_quo = r_quo[QUO_W-1];
    assign o_tag = r_tag[QUO_W-1];

endmodule

// ===== rtl/adam_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, with a tag carried alongside.
// Depends on nothing; the result is the floor of the root of the input.
module adam_sqrt #(
    parameter int IN_W  = 56,
    parameter int TAG_W = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [IN_W-1:0]     i_x,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_vld,
    output logic [IN_W/2-1:0]   o_root,
    output logic [TAG_W-1:0]    o_tag
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              r_vld  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [IN_W-1:0]   r_rest [ROOT_W];
    logic [TAG_W-1:0]  r_tag  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              s_vld;
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [IN_W-1:0]   s_rest;
        logic [TAG_W-1:0]  s_tag;
        logic [REM_W+1:0]  s_t;
        logic [REM_W+1:0]  s_trial;
        logic              s_take;

        if (k == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rest = i_x;
            assign s_tag  = i_tag;
        end else begin : g_next
            assign s_vld  = r_vld[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rest = r_rest[k-1];
            assign s_tag  = r_tag[k-1];
        end

        assign s_t     = {s_rem, s_rest[IN_W-1:IN_W-2]};
        assign s_trial = {2'b00, s_root, 2'b01};
        assign s_take  = s_t >= s_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= s_take ? REM_W'(s_t - s_trial) : REM_W'(s_t);
                r_root[k] <= {s_root[ROOT_W-2:0], s_take};
                r_rest[k] <= {s_rest[IN_W-3:0], 2'b00};
                r_tag[k]  <= s_tag;
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_tag  = r_tag[ROOT_W-1];

endmodule

// ===== rtl/adam_moment.sv =====
// Moment stores and the five stages that refresh the first and second moments.
// Uses adam_pkg; also holds the running beta powers and the store clearing pass.
module adam_moment (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_valid,
    input  adam_pkg::t_in_item                  i_item,
    input  logic [adam_pkg::RATE_W-1:0]         i_beta_first,
    input  logic [adam_pkg::RATE_W-1:0]         i_beta_second,
    output logic                                o_stall,
    output logic                                o_vld,
    output adam_pkg::t_moment                   o_res
);

    localparam int VW = adam_pkg::VAL_W;
    localparam int IW = adam_pkg::IDX_W;
    localparam int RW = adam_pkg::RATE_W;
    localparam int FR = adam_pkg::FRAC;

    logic [VW-1:0] r_mem_m [adam_pkg::ELEMENTS];
    logic [VW-1:0] r_mem_v [adam_pkg::ELEMENTS];

    logic          r_clearing;
    logic [IW-1:0] r_clr_addr;
    logic [RW-1:0] r_pow1, r_pow2;

    logic accept, hazard;

    // stage 1: item and store read data
    logic                 r1_vld, r1_act;
    logic [IW-1:0]        r1_idx;
    logic signed [VW-1:0] r1_g, r1_m;
    logic [VW-1:0]        r1_v;
    // stage 2: products for the first moment and the squared gradient
    logic                 r2_vld, r2_act;
    logic [IW-1:0]        r2_idx;
    logic [VW-1:0]        r2_v;
    logic signed [57:0]   r2_pm1, r2_pm2;
    logic [63:0]          r2_gg;
    // stage 3: new first moment, clipped squared gradient
    logic                 r3_vld, r3_act, r3_sat;
    logic [IW-1:0]        r3_idx;
    logic signed [VW-1:0] r3_m;
    logic [VW-1:0]        r3_v, r3_g2;
    // stage 4: products for the second moment
    logic                 r4_vld, r4_act, r4_sat;
    logic [IW-1:0]        r4_idx;
    logic signed [VW-1:0] r4_m;
    logic [56:0]          r4_pv1, r4_pv2;
    // stage 5: output
    logic                 r5_vld;
    adam_pkg::t_moment    r5_res;

    logic [VW-1:0]        n2_ag;
    logic signed [58:0]   s3_sum, s3_shift;
    logic [39:0]          s3_g2;
    logic [57:0]          s5_vsum;
    logic [33:0]          s5_vsh;
    logic [VW-1:0]        n5_v, n5_am;
    logic [2*RW-1:0]      s5_p1, s5_p2;

    assign hazard = (i_item.action == adam_pkg::ACT_UPDATE) && (
        (r1_vld && r1_act == adam_pkg::ACT_UPDATE && r1_idx == i_item.element_index) ||
        (r2_vld && r2_act == adam_pkg::ACT_UPDATE && r2_idx == i_item.element_index) ||
        (r3_vld && r3_act == adam_pkg::ACT_UPDATE && r3_idx == i_item.element_index) ||
        (r4_vld && r4_act == adam_pkg::ACT_UPDATE && r4_idx == i_item.element_index));

    assign o_stall = r_clearing || !i_adv || hazard;
    assign accept  = i_valid && !o_stall;

    assign n2_ag    = r1_g[VW-1] ? VW'(-r1_g) : VW'(r1_g);
    assign s3_sum   = 59'(r2_pm1) + 59'(r2_pm2);
    assign s3_shift = s3_sum >>> FR;
    assign s3_g2    = r2_gg[63:FR];
    assign s5_vsum  = {1'b0, r4_pv1} + {1'b0, r4_pv2};
    assign s5_vsh   = s5_vsum[57:FR];
    assign n5_v     = (|s5_vsh[33:32]) ? '1 : s5_vsh[VW-1:0];
    assign n5_am    = r4_m[VW-1] ? VW'(-r4_m) : VW'(r4_m);
    assign s5_p1    = r_pow1 * i_beta_first;
    assign s5_p2    = r_pow2 * i_beta_second;

    // Control state: clearing sweep, valid bits and beta powers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r4_vld     <= 1'b0;
            r5_vld     <= 1'b0;
            r_pow1     <= adam_pkg::ONE_Q;
            r_pow2     <= adam_pkg::ONE_Q;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == IW'(adam_pkg::ELEMENTS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_adv) begin
                r1_vld <= accept;
                r2_vld <= r1_vld;
                r3_vld <= r2_vld;
                r4_vld <= r3_vld;
                r5_vld <= r4_vld;
                if (r4_vld && r4_act == adam_pkg::ACT_ADVANCE) begin
                    r_pow1 <= s5_p1[RW+FR-1:FR];
                    r_pow2 <= s5_p2[RW+FR-1:FR];
                end
            end
        end
    end

    // Moment stores: one write port, one read port.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem_m[r_clr_addr] <= '0;
            r_mem_v[r_clr_addr] <= '0;
        end else if (i_adv && r4_vld && r4_act == adam_pkg::ACT_UPDATE) begin
            r_mem_m[r4_idx] <= r4_m;
            r_mem_v[r4_idx] <= n5_v;
        end
        if (accept) begin
            r1_m <= r_mem_m[i_item.element_index];
            r1_v <= r_mem_v[i_item.element_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_act <= i_item.action;
            r1_idx <= i_item.element_index;
            r1_g   <= i_item.gradient;

            r2_act <= r1_act;
            r2_idx <= r1_idx;
            r2_v   <= r1_v;
            r2_pm1 <= $signed({1'b0, i_beta_first}) * r1_m;
            r2_pm2 <= $signed({1'b0, RW'(adam_pkg::ONE_Q - i_beta_first)}) * r1_g;
            r2_gg  <= n2_ag * n2_ag;

            r3_act <= r2_act;
            r3_idx <= r2_idx;
            r3_v   <= r2_v;
            r3_m   <= s3_shift[VW-1:0];
            r3_g2  <= (|s3_g2[39:32]) ? '1 : s3_g2[VW-1:0];
            r3_sat <= |s3_g2[39:32];

            r4_act <= r3_act;
            r4_idx <= r3_idx;
            r4_m   <= r3_m;
            r4_sat <= r3_sat;
            r4_pv1 <= i_beta_second * r3_v;
            r4_pv2 <= RW'(adam_pkg::ONE_Q - i_beta_second) * r3_g2;

            r5_res.action <= r4_act;
            r5_res.idx    <= r4_idx;
            r5_res.mneg   <= r4_m[VW-1];
            r5_res.am     <= n5_am;
            r5_res.v      <= n5_v;
            r5_res.c1     <= adam_pkg::ONE_Q - adam_pkg::clamp_one(r_pow1);
            r5_res.c2     <= adam_pkg::ONE_Q - adam_pkg::clamp_one(r_pow2);
            r5_res.sat    <= r4_sat;
        end
    end

    assign o_vld = r5_vld;
    assign o_res = r5_res;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the fixed-point Adam update block.
// Depends on adam_pkg and adam_optimizer_update from the rtl folder.
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES = 150;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    adam_pkg::t_in_item            i_item;
    logic                          o_valid;
    logic                          i_stall;
    adam_pkg::t_out_item           o_result;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [1:0]                    i_cfg_index;
    logic [adam_pkg::RATE_W-1:0]   i_cfg_data;

    adam_optimizer_update i_dut (.*);

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the block's registers and stores.
    logic [adam_pkg::RATE_W-1:0]       lr_q, b1_q, b2_q, eps_q;
    logic signed [adam_pkg::VAL_W-1:0] m_store [adam_pkg::ELEMENTS];
    logic [adam_pkg::VAL_W-1:0]        v_store [adam_pkg::ELEMENTS];
    logic [adam_pkg::RATE_W-1:0]       pow1, pow2;

    adam_pkg::t_out_item step_queue[$];
    int        fail_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    function automatic logic [adam_pkg::RATE_W-1:0] sat_one(
        input logic [adam_pkg::RATE_W-1:0] x);
        return (x > adam_pkg::ONE_Q) ? adam_pkg::ONE_Q : x;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Works out the step for one item and updates the predicted state.
    function automatic adam_pkg::t_out_item adam_predict(input adam_pkg::t_in_item it);
        adam_pkg::t_out_item r;
        logic [63:0] b1, b2, c1, c2, ag, g2, v, am, mhat, vhat, eps, lrv, den, smag;
        logic signed [63:0] acc, m, g;
        logic [adam_pkg::IDX_W-1:0] ix;
        logic sat, mneg;
        b1  = sat_one(b1_q);
        b2  = sat_one(b2_q);
        sat = 1'b0;
        r   = '0;
        if (it.action == adam_pkg::ACT_ADVANCE) begin
            pow1 = (64'(pow1) * b1) >> adam_pkg::FRAC;
            pow2 = (64'(pow2) * b2) >> adam_pkg::FRAC;
            return r;
        end
        ix  = adam_pkg::IDX_W'(it.element_index % adam_pkg::ELEMENTS);
        g   = it.gradient;
        acc = $signed(b1) * 64'(m_store[ix]) + $signed(64'(adam_pkg::ONE_Q) - b1) * g;
        m   = acc >>> adam_pkg::FRAC;  // arithmetic shift floors toward minus infinity
        m_store[ix] = m[31:0];
        ag = (g < 0) ? -g : g;
        g2 = (ag * ag) >> adam_pkg::FRAC;
        if (g2 > 64'hFFFF_FFFF) begin
            g2  = 64'hFFFF_FFFF;
            sat = 1'b1;
        end
        v = (b2 * 64'(v_store[ix]) + (64'(adam_pkg::ONE_Q) - b2) * g2) >> adam_pkg::FRAC;
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        v_store[ix] = v[31:0];
        c1   = 64'(adam_pkg::ONE_Q) - sat_one(pow1);
        c2   = 64'(adam_pkg::ONE_Q) - sat_one(pow2);
        mneg = m < 0;
        am   = mneg ? -m : m;
        if (c1 == 0) begin
            mhat = (am == 0) ? 0 : (mneg ? 64'h8000_0000 : 64'h7FFF_FFFF);
            sat  = 1'b1;
        end else begin
            mhat = (am << adam_pkg::FRAC) / c1;
            if (mhat > (mneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
                mhat = mneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                sat  = 1'b1;
            end
        end
        if (c2 == 0) begin
            vhat = 64'hFFFF_FFFF;
            sat  = 1'b1;
        end else begin
            vhat = (v << adam_pkg::FRAC) / c2;
            if (vhat > 64'hFFFF_FFFF) begin
                vhat = 64'hFFFF_FFFF;
                sat  = 1'b1;
            end
        end
        eps = sat_one(eps_q);
        if (eps == 0) eps = 1;
        den  = root64(vhat << adam_pkg::FRAC) + eps;
        lrv  = sat_one(lr_q);
        smag = (mhat * lrv) / den;
        if (smag > (mneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            smag = mneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            sat  = 1'b1;
        end
        r.result_index = it.element_index;
        r.update_step  = mneg ? -smag[31:0] : smag[31:0];
        r.saturated    = sat;
        return r;
    endfunction

    // Receiver: random stall, and comparison of each accepted result.
    always @(posedge i_clk) begin
        adam_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (step_queue.size() == 0) begin
                    $display("%0t: result with none expected: %h", $time, o_result);
                    fail_count++;
                end else begin
                    want = step_queue.pop_front();
                    if (want.result_index != o_result.result_index) begin
                        $display("%0t: result_index expected %h actual %h", $time,
                                 want.result_index, o_result.result_index);
                        fail_count++;
                    end
                    if (want.update_step != o_result.update_step) begin
                        $display("%0t: update_step expected %h actual %h", $time,
                                 want.update_step, o_result.update_step);
                        fail_count++;
                    end
                    if (want.saturated != o_result.saturated) begin
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, o_result.saturated);
                        fail_count++;
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Sends one item, with random idle cycles first, and waits until accepted.
    // Valid stays high afterwards so that items can follow back to back.
    task automatic send_item(input adam_pkg::t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        step_queue.push_back(adam_predict(it));
    endtask

    task automatic send_update(input logic [adam_pkg::IDX_W-1:0] ix,
                               input logic [adam_pkg::VAL_W-1:0] g);
        adam_pkg::t_in_item it;
        it.action        = adam_pkg::ACT_UPDATE;
        it.element_index = ix;
        it.gradient      = g;
        send_item(it);
    endtask

    task automatic send_advance();
        adam_pkg::t_in_item it;
        it.action        = adam_pkg::ACT_ADVANCE;
        it.element_index = adam_pkg::IDX_W'($urandom);
        it.gradient      = $urandom;
        send_item(it);
    endtask

    // Waits for every result, then for the pipeline to empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (step_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input adam_pkg::t_cfg_reg idx,
                             input logic [adam_pkg::RATE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            adam_pkg::CFG_LEARNING_RATE: lr_q  = val;
            adam_pkg::CFG_BETA_FIRST:    b1_q  = val;
            adam_pkg::CFG_BETA_SECOND:   b2_q  = val;
            default:                     eps_q = val;
        endcase
    endtask

    task automatic set_regs(input logic [adam_pkg::RATE_W-1:0] lr,
                            input logic [adam_pkg::RATE_W-1:0] b1,
                            input logic [adam_pkg::RATE_W-1:0] b2,
                            input logic [adam_pkg::RATE_W-1:0] eps);
        write_reg(adam_pkg::CFG_LEARNING_RATE, lr);
        write_reg(adam_pkg::CFG_BETA_FIRST, b1);
        write_reg(adam_pkg::CFG_BETA_SECOND, b2);
        write_reg(adam_pkg::CFG_EPSILON, eps);
        i_cfg_valid <= 1'b0;
    endtask

    // Directed items: zero bias corrections before any advance, extreme
    // gradients, the highest index, then clamped and zero registers.
    task automatic test_directed();
        send_update(12'd0, 32'h0000_0000);
        send_update(12'd1, 32'h7FFF_FFFF);
        send_update(12'd2, 32'h8000_0000);
        send_update(12'hFFF, 32'hFFFF_FFFF);
        send_update(12'd3, 32'h0100_0000);
        send_advance();
        send_update(12'd1, 32'h7FFF_FFFF);
        send_update(12'd2, 32'h8000_0000);
        send_update(12'd3, 32'hFF00_0000);
        send_update(12'd1, 32'h7FFF_FFFF);  // same element back to back
        send_update(12'd1, 32'h8000_0000);
        send_advance();
        send_update(12'd5, 32'h0000_0001);
        drain();
        // Registers above 1.0 clamp, epsilon zero acts as one LSB.
        set_regs(25'h1FF_FFFF, 25'h1FF_FFFF, 25'd0, 25'd0);
        send_update(12'd6, 32'h4000_0000);
        send_advance();
        send_update(12'd6, 32'hC000_0000);
        send_update(12'd7, 32'h0000_0100);
        drain();
        set_regs(adam_pkg::ONE_Q, 25'd0, adam_pkg::ONE_Q, adam_pkg::ONE_Q);
        send_advance();
        send_update(12'd8, 32'h1234_5678);
        send_update(12'd9, 32'h8765_4321);
        drain();
    endtask

    function automatic logic [adam_pkg::VAL_W-1:0] rand_gradient();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(65535))) - 32768;
            2:       return $signed(32'($urandom)) >>> $urandom_range(31);
            default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [adam_pkg::RATE_W-1:0] rand_rate();
        case ($urandom_range(4))
            0:       return 25'd0;
            1:       return adam_pkg::ONE_Q;
            2:       return 25'($urandom);
            default: return adam_pkg::ONE_Q - 25'($urandom_range(4000000));
        endcase
    endfunction

    // One random phase: a few advances, updates on a small set of elements
    // so that moments build up and hazards occur, and some wide indexes.
    task automatic test_random_phase(input int n_items, input int idle_pct,
                                     input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(9) == 0) send_advance();
            else if ($urandom_range(3) == 0)
                send_update(adam_pkg::IDX_W'($urandom), rand_gradient());
            else send_update(adam_pkg::IDX_W'($urandom_range(7)), rand_gradient());
        end
        drain();
        set_regs(rand_rate(), rand_rate(), rand_rate(), rand_rate());
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = adam_pkg::CFG_LEARNING_RATE;
        i_cfg_data  = '0;
        lr_q  = adam_pkg::LR_RESET;
        b1_q  = adam_pkg::B1_RESET;
        b2_q  = adam_pkg::B2_RESET;
        eps_q = adam_pkg::EPS_RESET;
        pow1  = adam_pkg::ONE_Q;
        pow2  = adam_pkg::ONE_Q;
        for (int k = 0; k < adam_pkg::ELEMENTS; k++) begin
            m_store[k] = '0;
            v_store[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        set_regs(adam_pkg::LR_RESET, adam_pkg::B1_RESET, adam_pkg::B2_RESET,
                 adam_pkg::EPS_RESET);
        test_random_phase(300, 0, 0);
        test_random_phase(250, 86, 0);
        test_random_phase(250, 0, 86);
        test_random_phase(250, 30, 30);
        test_random_phase(200, 0, 0);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/adam_pkg.sv
rtl/adam_div.sv
rtl/adam_sqrt.sv
rtl/adam_moment.sv
rtl/adam_optimizer_update.sv
dv/testbench.sv
